// ===== hdl/itbd_pkg.sv =====
// Shared constants, types and helper functions for the integer-to-text converter.
// Used by the channel interfaces and every module under hdl/. No dependencies.
package itbd_pkg;

	// Defaults for top-level parameters
	localparam int MAX_SYMBOLS_DEF = 16;
	localparam int VALUE_BITS_DEF  = 32;
	localparam int QUEUE_DEPTH     = 2;

	// Field and register widths
	localparam int RADIX_W    = 5;
	localparam int DIG_W      = 5;
	localparam int SYM_W      = 8;
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 2;

	// Special characters and radix floor
	localparam logic [SYM_W-1:0]   SYM_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0]   SYM_MINUS = 8'h2D;
	localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

	// Register indexes (byte address / 8)
	localparam logic [REG_IDX_W-1:0] REG_RADIX  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SYM_LO = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SYM_HI = 2'd2;

	// Register reset values: decimal, alphabet "0123456789ABCDEF"
	localparam logic [RADIX_W-1:0]    RADIX_RST  = 5'd10;
	localparam logic [APB_DATA_W-1:0] SYM_LO_RST = 64'h3736353433323130;
	localparam logic [APB_DATA_W-1:0] SYM_HI_RST = 64'h4645444342413938;

	typedef struct packed {
		logic [RADIX_W-1:0]    radix;
		logic [APB_DATA_W-1:0] sym_lo;
		logic [APB_DATA_W-1:0] sym_hi;
	} cfg_t;

	// Converter to emitter handoff
	typedef struct packed {
		logic valid;
		logic neg;
	} handoff_t;

	typedef enum logic [1:0] {
		CONV_IDLE,
		CONV_RUN,
		CONV_DONE
	} conv_state_t;

	// Look up the symbol byte of a digit; digits past the registers read as zero
	function automatic logic [SYM_W-1:0] sym_at(input cfg_t cfg, input logic [DIG_W-1:0] k);
		logic [5:0]       bofs;
		logic [SYM_W-1:0] s;
		bofs = {k[2:0], 3'b000};
		priority if (k[4:3] == 2'b00) begin
			s = cfg.sym_lo[bofs +: SYM_W];
		end else if (k[4:3] == 2'b01) begin
			s = cfg.sym_hi[bofs +: SYM_W];
		end else begin
			s = '0;
		end
		return s;
	endfunction

endpackage

// ===== hdl/itbd_value_if.sv =====
// Input channel: one signed integer per transaction, valid/ready handshake.
// Depends on itbd_pkg for the default width.
interface itbd_value_if import itbd_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ===== hdl/itbd_char_if.sv =====
// Output channel: one character byte per transaction plus end-of-text flag.
// Depends on itbd_pkg for the symbol width.
interface itbd_char_if import itbd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             is_last;

	modport source (output valid, output symbol, output is_last, input ready);
	modport sink   (input valid, input symbol, input is_last, output ready);
endinterface

// ===== hdl/itbd_regs.sv =====
// APB register file: radix and the two alphabet words, 64-bit data, 8-byte stride.
// Depends on itbd_pkg for cfg_t, register indexes and reset values.
module itbd_regs import itbd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);
	logic [REG_IDX_W-1:0] idx;
	logic                 wr;
	cfg_t                 cfg_q;

	assign pready = 1'b1;
	assign idx    = paddr[APB_ADDR_W-1:3];
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Write on the access phase; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix  <= RADIX_RST;
			cfg_q.sym_lo <= SYM_LO_RST;
			cfg_q.sym_hi <= SYM_HI_RST;
		end else if (wr) begin
			unique case (idx)
				REG_RADIX:  cfg_q.radix  <= pwdata[RADIX_W-1:0];
				REG_SYM_LO: cfg_q.sym_lo <= pwdata;
				REG_SYM_HI: cfg_q.sym_hi <= pwdata;
				default:    ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (idx)
			REG_RADIX:  prdata = APB_DATA_W'(cfg_q.radix);
			REG_SYM_LO: prdata = cfg_q.sym_lo;
			REG_SYM_HI: prdata = cfg_q.sym_hi;
			default:    prdata = '0;
		endcase
	end
endmodule

// ===== hdl/itbd_front.sv =====
// Front end: accepts values, checks the alphabet, forms sign and magnitude.
// Depends on itbd_pkg and itbd_value_if; feeds the job queue.
module itbd_front import itbd_pkg::*; #(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	itbd_value_if.sink          din,
	input  cfg_t                cfg,
	input  logic                q_full,
	output logic                q_push,
	output logic [VALUE_BITS:0] q_data
);
	logic [SYM_W-1:0]      sym_v [MAX_SYMBOLS];
	logic                  ok;
	logic                  neg;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;

	assign din.ready = ~q_full;

	// Alphabet check: radix in range, no sign characters, no duplicates
	always_comb begin
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			sym_v[i] = sym_at(cfg, DIG_W'(i));
		end
		ok = (cfg.radix >= MIN_RADIX) &&
			({1'b0, cfg.radix} <= (RADIX_W + 1)'(MAX_SYMBOLS));
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			if (RADIX_W'(i) < cfg.radix) begin
				if (sym_v[i] == SYM_PLUS || sym_v[i] == SYM_MINUS) begin
					ok = 1'b0;
				end
				for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
					if (RADIX_W'(j) < cfg.radix && sym_v[j] == sym_v[i]) begin
						ok = 1'b0;
					end
				end
			end
		end
	end

	// Unsigned magnitude covers the most negative value
	assign raw = din.value;
	assign neg = raw[VALUE_BITS-1];
	assign mag = neg ? (~raw + VALUE_BITS'(1)) : raw;

	// Drop values when the alphabet is bad, queue the rest
	assign q_push = din.valid & din.ready & ok;
	assign q_data = {neg, mag};
endmodule

// ===== hdl/itbd_fifo.sv =====
// Short job queue between front end and converter.
// Depends on itbd_pkg for the default depth.
module itbd_fifo import itbd_pkg::*; #(
	parameter int WIDTH = VALUE_BITS_DEF + 1,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output logic [WIDTH-1:0] head
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end
endmodule

// ===== hdl/itbd_conv.sv =====
// Converter: a row of long-division cells; cell j divides the quotient stream
// of cell j-1 by the radix, so its final remainder is digit j. Uses itbd_pkg.
module itbd_conv import itbd_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [RADIX_W-1:0]                 radix,
	input  logic                               job_valid,
	input  logic [VALUE_BITS:0]                job_data,
	output logic                               job_pop,
	output handoff_t                           res,
	input  logic                               res_ready,
	output logic [VALUE_BITS-1:0][DIG_W-1:0]   res_digits,
	output logic [VALUE_BITS-1:0]              res_seen
);
	localparam int STEP_W = $clog2(2 * VALUE_BITS - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * VALUE_BITS - 2);

	conv_state_t                      state_q;
	conv_state_t                      state_nx;
	logic                             load;
	logic                             run;
	logic [STEP_W-1:0]                step_q;
	logic [VALUE_BITS-1:0]            mag_q;
	logic                             neg_q;
	logic [VALUE_BITS-1:0][DIG_W-1:0] rem_q;
	logic [VALUE_BITS-2:0]            qb_q;
	logic [VALUE_BITS-2:0]            vld_q;
	logic [VALUE_BITS-1:1]            seen_q;
	logic [VALUE_BITS-1:0]            bit_in;
	logic [VALUE_BITS-1:0]            vin;
	logic [VALUE_BITS-1:0]            ge;
	logic [DIG_W:0]                   tsh [VALUE_BITS];
	logic [VALUE_BITS-1:0][DIG_W-1:0] rem_nx;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			CONV_IDLE: if (job_valid) state_nx = CONV_RUN;
			CONV_RUN:  if (step_q == LAST_STEP) state_nx = CONV_DONE;
			CONV_DONE: if (res_ready) state_nx = job_valid ? CONV_RUN : CONV_IDLE;
			default:   state_nx = CONV_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		res.neg = neg_q;
		unique case (state_q)
			CONV_IDLE: begin
				load      = job_valid;
				run       = 1'b0;
				res.valid = 1'b0;
			end
			CONV_RUN: begin
				load      = 1'b0;
				run       = 1'b1;
				res.valid = 1'b0;
			end
			CONV_DONE: begin
				load      = res_ready & job_valid;
				run       = 1'b0;
				res.valid = 1'b1;
			end
			default: begin
				load      = 1'b0;
				run       = 1'b0;
				res.valid = 1'b0;
			end
		endcase
	end

	assign job_pop    = load;
	assign res_digits = rem_q;
	assign res_seen   = {seen_q, 1'b1};

	// Cell inputs: cell 0 takes magnitude bits MSB first, others the quotient of the previous cell
	always_comb begin
		bit_in[0] = mag_q[VALUE_BITS-1];
		vin[0]    = (step_q < STEP_W'(VALUE_BITS));
		for (int j = 1; j < VALUE_BITS; j++) begin
			bit_in[j] = qb_q[j-1];
			vin[j]    = vld_q[j-1];
		end
		for (int j = 0; j < VALUE_BITS; j++) begin
			tsh[j]    = {rem_q[j], bit_in[j]};
			ge[j]     = (tsh[j] >= {1'b0, radix});
			rem_nx[j] = ge[j] ? DIG_W'(tsh[j] - {1'b0, radix}) : DIG_W'(tsh[j]);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CONV_IDLE;
			step_q  <= '0;
			vld_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (load) begin
				step_q <= '0;
				vld_q  <= '0;
			end else if (run) begin
				step_q <= step_q + STEP_W'(1);
				vld_q  <= vin[VALUE_BITS-2:0];
			end
		end
	end

	// Cell datapath
	always_ff @(posedge clk) begin
		if (load) begin
			mag_q  <= job_data[VALUE_BITS-1:0];
			neg_q  <= job_data[VALUE_BITS];
			rem_q  <= '0;
			qb_q   <= '0;
			seen_q <= '0;
		end else if (run) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			for (int j = 0; j < VALUE_BITS; j++) begin
				if (vin[j]) begin
					rem_q[j] <= rem_nx[j];
				end
			end
			for (int j = 0; j < VALUE_BITS - 1; j++) begin
				qb_q[j] <= vin[j] & ge[j];
			end
			for (int j = 1; j < VALUE_BITS; j++) begin
				seen_q[j] <= seen_q[j] | (vin[j] & bit_in[j]);
			end
		end
	end
endmodule

// ===== hdl/itbd_emit.sv =====
// Emitter: holds one converted value and streams its characters, sign first,
// then digits from the most significant. Uses itbd_pkg and itbd_char_if.
module itbd_emit import itbd_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfg_t                             cfg,
	input  handoff_t                         res,
	output logic                             res_ready,
	input  logic [VALUE_BITS-1:0][DIG_W-1:0] res_digits,
	input  logic [VALUE_BITS-1:0]            res_seen,
	itbd_char_if.source                      dout
);
	logic [VALUE_BITS-1:0][DIG_W-1:0] bank_q;
	logic [VALUE_BITS-1:0]            ptr_q;
	logic                             minus_q;
	logic                             ov_q;
	logic [SYM_W-1:0]                 sym_q;
	logic                             last_q;
	logic [VALUE_BITS-1:0]            top_oh;
	logic [DIG_W-1:0]                 digit;
	logic                             busy;
	logic                             load;
	logic                             adv;

	// Most significant digit: top of the nonzero-quotient thermometer
	always_comb begin
		for (int j = 0; j < VALUE_BITS - 1; j++) begin
			top_oh[j] = res_seen[j] & ~res_seen[j+1];
		end
		top_oh[VALUE_BITS-1] = res_seen[VALUE_BITS-1];
	end

	// Select the digit under the one-hot pointer
	always_comb begin
		digit = '0;
		for (int j = 0; j < VALUE_BITS; j++) begin
			digit = digit | (bank_q[j] & {DIG_W{ptr_q[j]}});
		end
	end

	assign busy      = |ptr_q;
	assign res_ready = ~busy;
	assign load      = res.valid & res_ready;
	assign adv       = busy & (~ov_q | dout.ready);

	assign dout.valid   = ov_q;
	assign dout.symbol  = sym_q;
	assign dout.is_last = last_q;

	// Sequence control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			minus_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (load) begin
				ptr_q   <= top_oh;
				minus_q <= res.neg;
			end else if (adv) begin
				if (minus_q) begin
					minus_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q >> 1;
				end
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (dout.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Digit bank and output character
	always_ff @(posedge clk) begin
		if (load) begin
			bank_q <= res_digits;
		end
		if (adv) begin
			sym_q  <= minus_q ? SYM_MINUS : sym_at(cfg, digit);
			last_q <= ~minus_q & ptr_q[0];
		end
	end
endmodule

// ===== hdl/integer_to_base_digits.sv =====
// Signed integer to text in a configurable radix (2 up to MAX_SYMBOLS, symbols set over APB);
// one character per output transaction, '-' first for negatives, is_last on the final digit.
// In the converter, a row of VALUE_BITS division cells passes one bit per cycle along the row,
// then hands the result off to the emitter. The emitter streams the previous value's characters,
// one per cycle unless the output stalls, while the next value converts, so without output
// stalls the converter sets the sustained rate. A two-entry queue lets the input take values
// back to back while the converter is busy. With an invalid alphabet (radix out of range, a '+'
// or '-' symbol, or duplicate symbols) values are accepted and produce no output.
module integer_to_base_digits import itbd_pkg::*; #(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	itbd_value_if.sink            din,
	itbd_char_if.source           dout
);
	cfg_t                             cfg;
	logic                             q_push;
	logic [VALUE_BITS:0]              q_data;
	logic                             q_full;
	logic                             q_empty;
	logic                             q_pop;
	logic [VALUE_BITS:0]              q_head;
	handoff_t                         res;
	logic                             res_ready;
	logic [VALUE_BITS-1:0][DIG_W-1:0] res_digits;
	logic [VALUE_BITS-1:0]            res_seen;

	itbd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	itbd_front #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.VALUE_BITS  (VALUE_BITS)
	) u_front (
		.din    (din),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_data)
	);

	itbd_fifo #(
		.WIDTH (VALUE_BITS + 1),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	itbd_conv #(
		.VALUE_BITS (VALUE_BITS)
	) u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix      (cfg.radix),
		.job_valid  (~q_empty),
		.job_data   (q_head),
		.job_pop    (q_pop),
		.res        (res),
		.res_ready  (res_ready),
		.res_digits (res_digits),
		.res_seen   (res_seen)
	);

	itbd_emit #(
		.VALUE_BITS (VALUE_BITS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.res        (res),
		.res_ready  (res_ready),
		.res_digits (res_digits),
		.res_seen   (res_seen),
		.dout       (dout)
	);

	// Queue never written when full nor read when empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job queue read while empty");

	// A finished conversion waits until the emitter takes it
	a_handoff_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res_ready |=> res.valid && $stable(res.neg))
		else $error("converter result dropped before handoff");
endmodule
